// ===== rtl/core/itw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itw_pkg
// Token codes and widths for the integer-to-word-tokens unit.
// ----------------------------------------------------------------------------
package itw_pkg;

    localparam int unsigned NumWidth   = 31;
    localparam int unsigned TokWidth   = 5;
    localparam int unsigned BcdDigits  = 12;   // four groups of three digits
    localparam int unsigned BcdWidth   = 4 * BcdDigits;

    typedef logic [TokWidth-1:0] token_t;
    typedef logic [3:0]          digit_t;

    localparam token_t TOK_ZERO     = 5'd0;
    localparam token_t TOK_TEN      = 5'd10;
    localparam token_t TOK_TENS_OFS = 5'd18;   // Twenty is 20, tens digit 2
    localparam token_t TOK_HUNDRED  = 5'd28;
    localparam token_t TOK_THOUSAND = 5'd29;
    localparam token_t TOK_MILLION  = 5'd30;
    localparam token_t TOK_BILLION  = 5'd31;

endpackage : itw_pkg
`default_nettype wire

// ===== rtl/core/integer_to_word_tokens_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_word_tokens_unit
// Spells a 31-bit unsigned integer as a run of English word tokens.
// ----------------------------------------------------------------------------
// Sequence: shift-add-3 binary to BCD conversion after the item is accepted,
//   then a scan of 4 groups x 5 token slots at one slot per cycle while the
//   result side does not stall; each token is registered onto m_tdata. Zero
//   skips the scan and is sent as the single word Zero.
// Flow: s_tready is high only while idle, so a new item is accepted only after
//   the previous one is fully converted and scanned, one at a time through the
//   shared BCD adjust unit and the one-slot-per-cycle token scan.
// Reset: aresetn (sync, active low) returns the sequencer to idle and drops
//   m_tvalid; datapath registers are not reset.
// ----------------------------------------------------------------------------
module integer_to_word_tokens_unit
    import itw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] number, [31] zero pad
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [4:0] word_token, [7:5] zero pad
    output logic             m_tlast    // last_word
);

    localparam int unsigned ConvSteps = NumWidth;
    localparam int unsigned CntWidth  = $clog2(ConvSteps);

    typedef enum logic [1:0] {ST_IDLE, ST_CONVERT, ST_EMIT} state_t;

    // token slots within one group of three digits, in output order
    typedef enum logic [2:0] {
        SL_HUND_DIGIT, SL_HUND_WORD, SL_TENS, SL_ONES, SL_SCALE
    } slot_t;

    state_t                state_reg, state_next;
    slot_t                 slot_reg, slot_next;
    logic [1:0]            group_reg, group_next;   // 0 billions .. 3 units
    logic [CntWidth-1:0]   cnt_reg, cnt_next;
    logic [NumWidth-1:0]   bin_reg, bin_next;
    logic [BcdWidth-1:0]   bcd_reg, bcd_next;
    logic                  zero_reg, zero_next;
    logic                  m_valid_reg, m_valid_next;
    token_t                m_tok_reg, m_tok_next;
    logic                  m_last_reg, m_last_next;

    // shared adjust unit: add 3 to every BCD digit of 5 or more
    logic [BcdWidth-1:0]   bcd_adj;
    always_comb begin
        for (int d = 0; d < BcdDigits; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // group view: the units group (group 3) sits in the lowest twelve bits, flagged by group_nz[0]
    logic [3:0] group_nz;
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            group_nz[g] = |bcd_reg[12*g +: 12];
        end
    end

    digit_t h_dig, t_dig, o_dig;
    logic   rest_nz;       // a later group has a non-zero digit
    logic   has_scale;     // this group carries a scale word
    token_t scale_tok;
    always_comb begin
        unique case (group_reg)
            2'd0: begin
                {h_dig, t_dig, o_dig} = bcd_reg[47:36];
                rest_nz   = |group_nz[2:0];
                has_scale = 1'b1;
                scale_tok = TOK_BILLION;
            end
            2'd1: begin
                {h_dig, t_dig, o_dig} = bcd_reg[35:24];
                rest_nz   = |group_nz[1:0];
                has_scale = 1'b1;
                scale_tok = TOK_MILLION;
            end
            2'd2: begin
                {h_dig, t_dig, o_dig} = bcd_reg[23:12];
                rest_nz   = group_nz[0];
                has_scale = 1'b1;
                scale_tok = TOK_THOUSAND;
            end
            default: begin
                {h_dig, t_dig, o_dig} = bcd_reg[11:0];
                rest_nz   = 1'b0;
                has_scale = 1'b0;
                scale_tok = TOK_ZERO;
            end
        endcase
    end

    // token of the current slot, whether it exists, and whether one follows
    logic   grp_nz, is_teen, o_emits;
    logic   slot_emit, slot_more;
    token_t slot_tok;
    always_comb begin
        grp_nz  = (h_dig != 4'd0) || (t_dig != 4'd0) || (o_dig != 4'd0);
        is_teen = (t_dig == 4'd1);
        o_emits = (o_dig != 4'd0) && !is_teen;
        unique case (slot_reg)
            SL_HUND_DIGIT: begin
                slot_emit = (h_dig != 4'd0);
                slot_tok  = {1'b0, h_dig};
                slot_more = 1'b1;
            end
            SL_HUND_WORD: begin
                slot_emit = (h_dig != 4'd0);
                slot_tok  = TOK_HUNDRED;
                slot_more = (t_dig != 4'd0) || o_emits || has_scale || rest_nz;
            end
            SL_TENS: begin
                slot_emit = (t_dig != 4'd0);
                slot_tok  = is_teen ? TOK_TEN + {1'b0, o_dig}
                                    : TOK_TENS_OFS + {1'b0, t_dig};
                slot_more = o_emits || has_scale || rest_nz;
            end
            SL_ONES: begin
                slot_emit = o_emits;
                slot_tok  = {1'b0, o_dig};
                slot_more = has_scale || rest_nz;
            end
            default: begin
                slot_emit = grp_nz && has_scale;
                slot_tok  = scale_tok;
                slot_more = rest_nz;
            end
        endcase
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        group_next   = group_reg;
        cnt_next     = cnt_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg;
        m_tok_next   = m_tok_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    bin_next   = s_tdata[NumWidth-1:0];
                    bcd_next   = '0;
                    cnt_next   = '0;
                    zero_next  = (s_tdata[NumWidth-1:0] == '0);
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                bcd_next = {bcd_adj[BcdWidth-2:0], bin_reg[NumWidth-1]};
                bin_next = {bin_reg[NumWidth-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(ConvSteps - 1)) begin
                    state_next = ST_EMIT;
                    group_next = 2'd0;
                    slot_next  = SL_HUND_DIGIT;
                end
            end
            default: begin
                if (zero_reg) begin
                    // zero spells as the single word Zero
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_tok_next   = TOK_ZERO;
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (!slot_emit || out_free) begin
                    if (slot_emit) begin
                        m_valid_next = 1'b1;
                        m_tok_next   = slot_tok;
                        m_last_next  = !slot_more;
                    end
                    unique case (slot_reg)
                        SL_HUND_DIGIT: slot_next = SL_HUND_WORD;
                        SL_HUND_WORD:  slot_next = SL_TENS;
                        SL_TENS:       slot_next = SL_ONES;
                        SL_ONES:       slot_next = SL_SCALE;
                        default: begin
                            slot_next = SL_HUND_DIGIT;
                            if (group_reg == 2'd3) begin
                                state_next = ST_IDLE;
                            end else begin
                                group_next = group_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= SL_HUND_DIGIT;
            group_reg   <= 2'd0;
            cnt_reg     <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            group_reg   <= group_next;
            cnt_reg     <= cnt_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        m_tok_reg  <= m_tok_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_tok_reg};
    assign m_tlast  = m_last_reg;

endmodule : integer_to_word_tokens_unit
`default_nettype wire

// ===== sim/tb_integer_to_word_tokens_unit.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_word_tokens_unit
// Self-checking bench for the integer-to-word-tokens unit. A queue of numbers
// feeds a bursty stream driver. Each accepted number is spelled out here into
// the token run it should produce. A monitor with its own stall patterns pulls
// tokens off the result stream and checks each one against the oldest
// expected token. The check covers both the token code and the end-of-run flag.
// ----------------------------------------------------------------------------
module tb_integer_to_word_tokens_unit;
    import itw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RandomItems = 455;
    localparam int unsigned CycleLimit  = 1000000;
    localparam int unsigned DrainCycles = 60;    // > one full convert + scan
    localparam int unsigned HoldCycles  = 600;   // long result-side stall
    localparam int unsigned ReportMax   = 10;

    typedef struct packed {
        token_t word;
        logic   last;
    } spelled_word_t;

    // result-side stall patterns
    typedef enum logic [2:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PULSED
    } ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [30:0] number, [31] zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [4:0] word_token, [7:5] zero pad
    logic        m_tlast;         // last_word

    logic [NumWidth-1:0] numbers_to_send_q [$];
    spelled_word_t       spelled_words_q [$];

    int unsigned accepted_count = 0;
    int unsigned items_total    = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // sender burst state
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // receiver stall state
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int unsigned mode_left   = 0;
    int unsigned pulse_phase = 0;
    logic        ready_next;
    int unsigned hold_left   = 0;
    int unsigned holds_done  = 0;

    spelled_word_t oldest_word;

    integer_to_word_tokens_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Spelling predictor: appends the token run for one number to the
    // expected queue. Groups of three digits, most significant first; an
    // all-zero group is skipped along with its scale word.
    // ------------------------------------------------------------------------
    function automatic void expect_spelling(input logic [NumWidth-1:0] number);
        int unsigned value;
        int unsigned grp;
        int unsigned hund;
        int unsigned rest;
        int unsigned divisor [4];
        token_t      scale_word [4];
        token_t      run [$];
        spelled_word_t sw;
        value      = {1'b0, number};
        divisor    = '{1000000000, 1000000, 1000, 1};
        scale_word = '{TOK_BILLION, TOK_MILLION, TOK_THOUSAND, TOK_ZERO};
        if (value == 0) begin
            run.push_back(TOK_ZERO);
        end else begin
            for (int i = 0; i < 4; i++) begin
                grp = (value / divisor[i]) % 1000;
                if (grp == 0)
                    continue;
                hund = grp / 100;
                rest = grp % 100;
                if (hund != 0) begin
                    run.push_back(token_t'(hund));
                    run.push_back(TOK_HUNDRED);
                end
                // ten to nineteen is one word of its own
                if (rest >= 10 && rest < 20) begin
                    run.push_back(token_t'(rest));
                end else begin
                    if (rest / 10 != 0)
                        run.push_back(TOK_TENS_OFS + token_t'(rest / 10));
                    if (rest % 10 != 0)
                        run.push_back(token_t'(rest % 10));
                end
                if (i < 3)
                    run.push_back(scale_word[i]);
            end
        end
        foreach (run[k]) begin
            sw.word = run[k];
            sw.last = (k == run.size() - 1);
            spelled_words_q.push_back(sw);
        end
    endfunction

    // one group of three digits, biased toward the interesting shapes
    function automatic int unsigned random_group();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return $urandom_range(10, 19);
            2:       return $urandom_range(1, 9) * 100 + $urandom_range(10, 19);
            3:       return $urandom_range(1, 9) * 100;
            4:       return $urandom_range(1, 9) * 10;
            5:       return $urandom_range(1, 99);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= ReportMax)
            $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers numbers in bursts with random gaps. During the long
    // receiver hold-off the gaps are skipped so the input side backs up.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expect_spelling(s_tdata[NumWidth-1:0]);
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
                if (hold_left != 0)
                    gap_left = 0;
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (numbers_to_send_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, numbers_to_send_q.pop_front()};
                    burst_left--;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off: twice in the run the receiver stops for HoldCycles while
    // the driver keeps offering, so the block fills and drops s_tready.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && accepted_count >= 30) ||
                     (holds_done == 1 && accepted_count >= 300)) begin
            hold_left  <= HoldCycles;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted token against the oldest expected one
    // and drives m_tready from a stall pattern that is redrawn at random
    // intervals.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (spelled_words_q.size() == 0) begin
                    note_failure($sformatf("unexpected token %0d last %0b",
                                           m_tdata[TokWidth-1:0], m_tlast));
                end else begin
                    oldest_word = spelled_words_q.pop_front();
                    if (m_tdata[TokWidth-1:0] !== oldest_word.word ||
                        m_tlast !== oldest_word.last)
                        note_failure($sformatf(
                            "token %0d last %0b, expected token %0d last %0b",
                            m_tdata[TokWidth-1:0], m_tlast,
                            oldest_word.word, oldest_word.last));
                end
            end

            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 4));
                mode_left  = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            pulse_phase = (pulse_phase + 1) % 13;
            case (ready_mode)
                RDY_ALWAYS: ready_next = 1'b1;
                RDY_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
                RDY_HALF:   ready_next = ($urandom_range(0, 1) != 0);
                RDY_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
                default:    ready_next = (pulse_phase < 8);
            endcase
            m_tready <= ready_next && (hold_left == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] composed;
        int unsigned directed [$];

        // extremes, each scale word, teens, zero groups, longest run
        directed = '{0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 119, 999,
                     1000, 1001, 12013, 1000000, 100000000, 1000000000,
                     1000000001, 1777777777, 2013014015, 2147483647};
        foreach (directed[i])
            numbers_to_send_q.push_back(directed[i][NumWidth-1:0]);

        for (int i = 0; i < RandomItems; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    // raw 31-bit value: exercises every input bit
                    numbers_to_send_q.push_back(NumWidth'($urandom()));
                end
                1: begin
                    numbers_to_send_q.push_back(NumWidth'($urandom_range(0, 1999)));
                end
                default: begin
                    composed = 64'(random_group()) + 64'(random_group()) * 1000 +
                               64'(random_group()) * 1000000 +
                               64'($urandom_range(0, 2)) * 1000000000;
                    if (composed > 64'h7FFF_FFFF)
                        composed = composed - 64'd1000000000;
                    numbers_to_send_q.push_back(composed[NumWidth-1:0]);
                end
            endcase
        end
        items_total = numbers_to_send_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < items_total || spelled_words_q.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (spelled_words_q.size() != 0)
            note_failure($sformatf("%0d tokens never arrived", spelled_words_q.size()));

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : tb_integer_to_word_tokens_unit

// ===== filelist.f =====
rtl/core/itw_pkg.sv
rtl/core/integer_to_word_tokens_unit.sv
sim/tb_integer_to_word_tokens_unit.sv
